/* rtl/afrlp_pkg.sv */
// ----------------------------------------------------------------------------
// afrlp_pkg
// Shared types and constants of the API receive frame level parser.
// ----------------------------------------------------------------------------
package afrlp_pkg;

    // Frame delimiter
    localparam logic [7:0] START_BYTE = 8'h7E;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CEILING = 1'b1;

    localparam logic [7:0] GAIN_RESET    = 8'd15;
    localparam logic [7:0] CEILING_RESET = 8'd250;

    // Depth of the queue between the framer and the level stage
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Outcome of one complete frame, handed from framer to level stage
    typedef struct packed {
        logic       bad;
        logic [7:0] payload;
    } verdict_t;

endpackage

/* rtl/afrlp_in_if.sv */
// ----------------------------------------------------------------------------
// afrlp_in_if
// Byte stream channel into the parser: one serial byte per beat.
// ----------------------------------------------------------------------------
interface afrlp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

/* rtl/afrlp_out_if.sv */
// ----------------------------------------------------------------------------
// afrlp_out_if
// Result channel out of the parser: a new level or a checksum error per beat.
// ----------------------------------------------------------------------------
interface afrlp_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] level;
    logic       checksum_error;

    modport source (output valid, output level, output checksum_error, input ready);
    modport sink   (input valid, input level, input checksum_error, output ready);

endinterface

/* rtl/api_frame_rx_level_parser.sv */
// ----------------------------------------------------------------------------
// api_frame_rx_level_parser
// Parses API receive frames from a byte stream and reports level changes.
// ----------------------------------------------------------------------------
// The block takes one serial byte per clock cycle with no bubbles, as long as
// the result side keeps up. A result passes through the verdict queue and the
// product and output registers of the level stage before it is offered on the
// port. A stalled result side fills the queue of QUEUE_DEPTH frame verdicts,
// and only then holds off the checksum byte of the next frame; all other bytes
// are always taken. The user must write gain and ceiling through the
// configuration port only while no frame is in flight; the block itself does
// not enforce this. After reset the block is ready at once.
module api_frame_rx_level_parser
    import afrlp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    afrlp_in_if.sink               rx,
    afrlp_out_if.source            res
);

    logic [7:0] gain_reg;
    logic [7:0] ceiling_reg;
    logic       push;
    logic       push_ready;
    verdict_t   push_data;
    logic       pop;
    logic       pop_valid;
    verdict_t   pop_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RESET;
            ceiling_reg <= CEILING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:    gain_reg    <= cfg_data[7:0];
                REG_CEILING: ceiling_reg <= cfg_data[7:0];
            endcase
        end
    end

    afrlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    afrlp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    afrlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .ceiling   (ceiling_reg),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop),
        .res       (res)
    );

endmodule

/* rtl/afrlp_front.sv */
// ----------------------------------------------------------------------------
// afrlp_front
// Framer: hunts for the start byte, sums the frame body and checks the
// checksum byte, then pushes one verdict per frame into the queue.
// ----------------------------------------------------------------------------
module afrlp_front
    import afrlp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    afrlp_in_if.sink   rx,
    output logic       push,
    output verdict_t   push_data,
    input  logic       push_ready
);

    // Position within the frame
    localparam logic [4:0] PH_HUNT      = 5'd0;
    localparam logic [4:0] PH_LEN_HI    = 5'd1;
    localparam logic [4:0] PH_LEN_LO    = 5'd2;
    localparam logic [4:0] PH_FIRST_SUM = 5'd3;
    localparam logic [4:0] PH_PAYLOAD   = 5'd15;
    localparam logic [4:0] PH_CHECK     = 5'd16;

    logic [4:0] phase_reg;
    logic [4:0] phase_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] payload_reg;
    logic [7:0] payload_next;
    logic       beat;

    // Stall only on the checksum byte, and only while the queue is full
    assign rx.ready = (phase_reg != PH_CHECK) || push_ready;
    assign beat     = rx.valid && rx.ready;

    // Push the frame outcome with the checksum byte
    assign push              = beat && (phase_reg == PH_CHECK);
    assign push_data.bad     = (rx.rx_byte != ~sum_reg);
    assign push_data.payload = payload_reg;

    // Advance the frame position on every beat, but in the hunt only on a start byte
    always_comb
    begin
        phase_next   = phase_reg;
        sum_next     = sum_reg;
        payload_next = payload_reg;
        if (beat)
        begin
            unique case (phase_reg) inside
                PH_HUNT:
                begin
                    if (rx.rx_byte == START_BYTE)
                    begin
                        phase_next = PH_LEN_HI;
                        sum_next   = 8'd0;
                    end
                end
                PH_LEN_HI, PH_LEN_LO:
                begin
                    phase_next = phase_reg + 5'd1;
                end
                [PH_FIRST_SUM:PH_PAYLOAD]:
                begin
                    sum_next   = sum_reg + rx.rx_byte;
                    phase_next = phase_reg + 5'd1;
                    if (phase_reg == PH_PAYLOAD)
                    begin
                        payload_next = rx.rx_byte;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Body sum and payload need no reset: hunting overwrites the sum first
    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        payload_reg <= payload_next;
    end

endmodule

/* rtl/afrlp_queue.sv */
// ----------------------------------------------------------------------------
// afrlp_queue
// Short verdict queue that decouples the framer from the level stage.
// ----------------------------------------------------------------------------
module afrlp_queue
    import afrlp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  verdict_t push_data,
    output logic     push_ready,
    input  logic     pop,
    output logic     pop_valid,
    output verdict_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    verdict_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // Write the incoming verdict at the tail
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/afrlp_back.sv */
// ----------------------------------------------------------------------------
// afrlp_back
// Level stage: scales the payload by the gain, clamps at the ceiling and
// emits the level when it changes, or flags a checksum error.
// ----------------------------------------------------------------------------
module afrlp_back
    import afrlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  gain,
    input  logic [7:0]  ceiling,
    input  logic        pop_valid,
    input  verdict_t    pop_data,
    output logic        pop,
    afrlp_out_if.source res
);

    // Product stage
    logic        mul_valid_reg;
    logic        mul_bad_reg;
    logic [15:0] mul_prod_reg;

    // Output stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_level_reg;
    logic [7:0]  out_level_next;
    logic        out_err_reg;
    logic        out_err_next;
    logic [7:0]  prev_level_reg;
    logic [7:0]  prev_level_next;

    logic        mul_move;
    logic [7:0]  clamped;

    assign mul_move = mul_valid_reg && (!out_valid_reg || res.ready);
    assign pop      = pop_valid && (!mul_valid_reg || mul_move);
    assign clamped  = (mul_prod_reg > {8'd0, ceiling}) ? ceiling : mul_prod_reg[7:0];

    // Load the product stage from the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (pop || mul_move)
        begin
            mul_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mul_bad_reg  <= pop_data.bad;
            mul_prod_reg <= pop_data.payload * gain;
        end
    end

    // Decide the result and keep the last good level
    always_comb
    begin
        out_valid_next  = out_valid_reg && !res.ready;
        out_level_next  = out_level_reg;
        out_err_next    = out_err_reg;
        prev_level_next = prev_level_reg;
        if (mul_move)
        begin
            if (mul_bad_reg)
            begin
                out_valid_next = 1'b1;
                out_level_next = 8'd0;
                out_err_next   = 1'b1;
            end
            else
            begin
                prev_level_next = clamped;
                out_valid_next  = (clamped != prev_level_reg);
                out_level_next  = clamped;
                out_err_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            prev_level_reg <= 8'd0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            prev_level_reg <= prev_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_level_reg <= out_level_next;
        out_err_reg   <= out_err_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.level          = out_level_reg;
    assign res.checksum_error = out_err_reg;

endmodule

/* rtl/afrlp_checker.sv */
// ----------------------------------------------------------------------------
// afrlp_checker
// Port-level checks of the level parser, bound to the top level.
// ----------------------------------------------------------------------------
module afrlp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_level,
    input logic       res_err
);

    logic [7:0] last_good_reg;
    logic       res_beat;

    assign res_beat = res_valid && res_ready;

    // Track the last good level delivered; the kept level starts at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_good_reg <= 8'd0;
        end
        else if (res_beat && !res_err)
        begin
            last_good_reg <= res_level;
        end
    end

    // An error beat carries a zero level
    a_err_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_err |-> res_level == 8'd0)
        else $error("checksum error beat with non-zero level");

    // A good level never repeats the one delivered before it
    a_level_changes: assert property (@(posedge clk) disable iff (!rst_n)
        res_beat && !res_err |-> res_level != last_good_reg)
        else $error("unchanged level delivered");

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            res_valid && $stable(res_level) && $stable(res_err))
        else $error("stalled result changed");

endmodule

bind api_frame_rx_level_parser afrlp_checker u_afrlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_level (res.level),
    .res_err   (res.checksum_error)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the API receive frame level parser. A short table
// of hand-built frames is followed by randomised frames under several gain
// and ceiling settings. Every byte taken by the block is run through a local
// model of the framer and level stage; result beats are compared in order.
// ----------------------------------------------------------------------------
module tb_top;

    import afrlp_pkg::*;

    // Frame positions of the local model
    localparam logic [4:0] FRAME_HUNT      = 5'd0;
    localparam logic [4:0] FRAME_FIRST_SUM = 5'd3;
    localparam logic [4:0] FRAME_PAYLOAD   = 5'd15;

    localparam int BYTE_TARGET   = 1950;
    localparam int NUM_SETTINGS  = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_LIMIT    = 2000;

    // How the result of a checksum byte is known
    typedef enum {CHK_PREDICT, CHK_NONE, CHK_LEVEL, CHK_ERROR} frame_check_t;

    typedef struct packed {
        logic [7:0] level;
        logic       checksum_error;
    } level_result_t;

    typedef struct {
        int           noise;
        logic [7:0]   fill;
        logic [7:0]   payload;
        bit           corrupt;
        frame_check_t check;
        logic [7:0]   level;
    } frame_row_t;

    typedef struct packed {
        logic [7:0] gain;
        logic [7:0] ceiling;
    } level_cfg_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    afrlp_in_if  rx ();
    afrlp_out_if res ();

    api_frame_rx_level_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .res       (res)
    );

    // Local copy of parser state and registers
    logic [4:0] frame_pos     = FRAME_HUNT;
    logic [7:0] frame_sum     = 8'd0;
    logic [7:0] frame_payload = 8'd0;
    logic [7:0] last_level    = 8'd0;
    logic [7:0] gain_q        = GAIN_RESET;
    logic [7:0] ceiling_q     = CEILING_RESET;

    level_result_t level_expect_q[$];

    int  fail_count    = 0;
    int  frame_bytes   = 0;
    int  frames_sent   = 0;
    int  levels_seen   = 0;
    int  errors_seen   = 0;
    int  idle_cycles   = 0;
    int  stall_left    = 0;
    bit  sender_calm   = 1'b0;
    bit  sink_calm     = 1'b0;

    // Hand-built frames, reset gain and ceiling in force
    frame_row_t opening_frames [0:10] = '{
        '{3, 8'h00, 8'h00, 1'b0, CHK_NONE,    8'd0},
        '{0, 8'h00, 8'h01, 1'b0, CHK_LEVEL,   8'd15},
        '{0, 8'hFF, 8'hFF, 1'b0, CHK_LEVEL,   8'd250},
        '{0, 8'h7E, 8'h7E, 1'b0, CHK_PREDICT, 8'd0},
        '{0, 8'h12, 8'h03, 1'b1, CHK_ERROR,   8'd0},
        '{0, 8'h00, 8'h03, 1'b0, CHK_PREDICT, 8'd0},
        '{5, 8'h7E, 8'h10, 1'b1, CHK_ERROR,   8'd0},
        '{0, 8'hA5, 8'h00, 1'b0, CHK_LEVEL,   8'd0},
        '{0, 8'h5A, 8'h0A, 1'b0, CHK_PREDICT, 8'd0},
        '{0, 8'h00, 8'h11, 1'b0, CHK_PREDICT, 8'd0},
        '{2, 8'h7E, 8'h7E, 1'b1, CHK_ERROR,   8'd0}
    };

    level_cfg_t cfg_plan [0:NUM_SETTINGS-1] = '{
        '{8'd0,   8'd255},
        '{8'd255, 8'd255},
        '{8'd1,   8'd0},
        '{8'd255, 8'd0},
        '{8'd3,   8'd200},
        '{8'd7,   8'd100},
        '{8'd2,   8'd60},
        '{GAIN_RESET, CEILING_RESET}
    };

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Advance the local model by one taken byte; return 1 when a result is due
    function automatic bit predict_level(input logic [7:0] b, output level_result_t r);
        logic [15:0] product;
        logic [7:0]  lvl;
        predict_level = 1'b0;
        r = '0;
        if (frame_pos == FRAME_HUNT)
        begin
            if (b == START_BYTE)
            begin
                frame_pos = 5'd1;
                frame_sum = 8'd0;
            end
        end
        else if (frame_pos < FRAME_FIRST_SUM)
        begin
            frame_pos = frame_pos + 5'd1;
        end
        else if (frame_pos <= FRAME_PAYLOAD)
        begin
            frame_sum = frame_sum + b;
            if (frame_pos == FRAME_PAYLOAD)
                frame_payload = b;
            frame_pos = frame_pos + 5'd1;
        end
        else
        begin
            frame_pos = FRAME_HUNT;
            if (b != 8'hFF - frame_sum)
            begin
                r.level          = 8'd0;
                r.checksum_error = 1'b1;
                predict_level    = 1'b1;
            end
            else
            begin
                product = frame_payload * gain_q;
                lvl = (product > {8'd0, ceiling_q}) ? ceiling_q : product[7:0];
                if (lvl != last_level)
                begin
                    r.level       = lvl;
                    predict_level = 1'b1;
                end
                last_level = lvl;
            end
        end
    endfunction

    // Mostly no gap, some short, a few long
    function automatic int pick_gap(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == START_BYTE);
        return b;
    endfunction

    function automatic logic [7:0] body_byte();
        if ($urandom_range(0, 7) == 0)
            return START_BYTE;
        return 8'($urandom);
    endfunction

    // Offer one byte, hold it until taken, then file what it should cause
    task automatic send_byte(input logic [7:0] b, input frame_check_t check = CHK_PREDICT,
                             input logic [7:0] typed_level = 8'd0);
        int            gap;
        level_result_t r;
        bit            due;
        gap = pick_gap(sender_calm);
        if (gap > 0)
        begin
            rx.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (!rx.ready)
            @(posedge clk);
        if (frame_pos != FRAME_HUNT || b == START_BYTE)
            frame_bytes++;
        due = predict_level(b, r);
        case (check)
            CHK_PREDICT: if (due) level_expect_q.push_back(r);
            CHK_LEVEL:   level_expect_q.push_back('{level: typed_level, checksum_error: 1'b0});
            CHK_ERROR:   level_expect_q.push_back('{level: 8'd0, checksum_error: 1'b1});
            default:     ;
        endcase
    endtask

    // One complete frame with a correct or a damaged checksum
    task automatic send_frame(input int noise, input logic [7:0] fill, input bit shuffle,
                              input logic [7:0] payload, input bit corrupt,
                              input frame_check_t check, input logic [7:0] typed_level);
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] chk;
        sum = 8'd0;
        repeat (noise) send_byte(noise_byte());
        send_byte(START_BYTE);
        repeat (2) send_byte(shuffle ? 8'($urandom) : fill);
        repeat (12)
        begin
            b = shuffle ? body_byte() : fill;
            sum = sum + b;
            send_byte(b);
        end
        sum = sum + payload;
        send_byte(payload);
        chk = 8'hFF - sum;
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk, check, typed_level);
        frames_sent++;
    endtask

    // Well-formed frames mostly; some noise and cut-short frames
    task automatic send_random_frame();
        logic [7:0] payload;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) send_byte(noise_byte());
        if ($urandom_range(0, 9) == 0)
        begin
            send_byte(START_BYTE);
            repeat ($urandom_range(1, 15)) send_byte(body_byte());
        end
        else
        begin
            payload = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
            send_frame(0, 8'd0, 1'b1, payload, $urandom_range(0, 3) == 0, CHK_PREDICT, 8'd0);
        end
    endtask

    // Close any open frame, stop sending and wait for every result
    task automatic drain_results();
        while (frame_pos != FRAME_HUNT)
            send_byte(8'($urandom));
        rx.valid <= 1'b0;
        while (level_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_levels_cfg(input level_cfg_t setting);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_data  <= setting.gain;
        @(posedge clk);
        cfg_index <= REG_CEILING;
        cfg_data  <= setting.ceiling;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gain_q    = setting.gain;
        ceiling_q = setting.ceiling;
    endtask

    // Compare one result beat with the oldest expectation
    task automatic check_level_result(input logic [7:0] level, input logic checksum_error);
        level_result_t exp_r;
        if (level_expect_q.size() == 0)
        begin
            $display("%0t: unexpected result beat, got level %0d error %0b",
                     $time, level, checksum_error);
            fail_count++;
        end
        else
        begin
            exp_r = level_expect_q.pop_front();
            if (checksum_error !== exp_r.checksum_error)
            begin
                $display("%0t: checksum_error mismatch, expected %0b, got %0b",
                         $time, exp_r.checksum_error, checksum_error);
                fail_count++;
            end
            if (level !== exp_r.level)
            begin
                $display("%0t: level mismatch, expected %0d, got %0d",
                         $time, exp_r.level, level);
                fail_count++;
            end
            if (exp_r.checksum_error)
                errors_seen++;
            else
                levels_seen++;
        end
    endtask

    // Result side: check beats, stall at random
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            check_level_result(res.level, res.checksum_error);
        if (stall_left > 0)
        begin
            res.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            res.ready <= 1'b1;
            stall_left = pick_gap(sink_calm);
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((rx.valid && rx.ready) || (res.valid && res.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int budget;
        int phase_start;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_GAIN;
        cfg_data   = '0;
        rx.valid   = 1'b0;
        rx.rx_byte = 8'd0;
        res.ready  = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under reset gain and ceiling
        foreach (opening_frames[i])
            send_frame(opening_frames[i].noise, opening_frames[i].fill, 1'b0,
                       opening_frames[i].payload, opening_frames[i].corrupt,
                       opening_frames[i].check, opening_frames[i].level);

        // Share what is left of the byte target between the settings
        budget = (BYTE_TARGET - frame_bytes) / NUM_SETTINGS;

        // Random frames under each setting, block idle for each write
        cfg_plan[5] = '{gain: 8'($urandom), ceiling: 8'($urandom)};
        cfg_plan[6] = '{gain: 8'($urandom_range(1, 20)), ceiling: 8'($urandom)};
        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            drain_results();
            write_levels_cfg(cfg_plan[p]);
            sender_calm = (p == 2);
            sink_calm   = (p == 2) || (p == 5);
            phase_start = frame_bytes;
            while (frame_bytes - phase_start < budget)
                send_random_frame();
        end
        drain_results();

        if (level_expect_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, level_expect_q.size());
            fail_count++;
        end
        $display("Covered %0d frames, %0d framed bytes, %0d settings of gain and ceiling",
                 frames_sent, frame_bytes, NUM_SETTINGS + 1);
        $display("Checked %0d new levels and %0d checksum errors, %0d mismatches",
                 levels_seen, errors_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
